>>> src/gpir_pkg.sv
// Shared package for the game-port input register unit.
// Holds access kinds, port modes, potgo masks and the field widths.
// No dependencies.
`default_nettype none

package gpir_pkg;

	localparam int unsigned AXIS_W = 16;
	localparam int unsigned CNT_W  = 8;
	localparam int unsigned DATA_W = 16;
	localparam int unsigned BTN_W  = 3;
	localparam int unsigned KIND_W = 3;
	localparam int unsigned MODE_W = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_POTGO_WRITE = 3'd0,
		KIND_POTGO_READ  = 3'd1,
		KIND_POT0_READ   = 3'd2,
		KIND_PORT0_READ  = 3'd3,
		KIND_PORT1_READ  = 3'd4,
		KIND_TEST_WRITE  = 3'd5
	} kind_t;

	localparam logic [MODE_W-1:0] MODE_MOUSE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_JOY   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_NONE  = 2'd2;

	// configuration register indexes (paddr[3:2])
	localparam logic [1:0] REG_PORT0_MODE = 2'd0;
	localparam logic [1:0] REG_PORT1_MODE = 2'd1;
	localparam logic [1:0] REG_RAW        = 2'd2;

	localparam logic [DATA_W-1:0] POT_DATA_MASK = 16'h5500;
	localparam logic [DATA_W-1:0] POT_DIR_MASK  = 16'hAA00;
	localparam logic [DATA_W-1:0] P0_PIN_A_CLR  = 16'hFBFF;
	localparam logic [DATA_W-1:0] P0_PIN_B_CLR  = 16'hFEFF;
	localparam logic [DATA_W-1:0] P1_PIN_A_CLR  = 16'hBFFF;
	localparam logic [DATA_W-1:0] P1_PIN_B_CLR  = 16'hEFFF;
	localparam logic [CNT_W-1:0]  TEST_MASK     = 8'hFC;
	localparam int signed         DELTA_LIMIT   = 127;

	typedef struct packed {
		logic [MODE_W-1:0] port0_mode;
		logic [MODE_W-1:0] port1_mode;
		logic              raw;
	} cfg_t;

	// Fold button presses into the pot pin image, per port mode.
	function automatic logic [DATA_W-1:0] pot_pin_image(
		input logic [DATA_W-1:0] pg,
		input cfg_t              cfg,
		input logic [BTN_W-1:0]  mb,
		input logic [BTN_W-1:0]  j0,
		input logic [BTN_W-1:0]  j1
	);
		logic [DATA_W-1:0] v;
		v = ((pg | (pg >> 1)) & POT_DATA_MASK) | ((~pg & POT_DIR_MASK) >> 1);
		if (cfg.port0_mode == MODE_MOUSE) begin
			if (mb[2]) v = v & P0_PIN_A_CLR;
			if (mb[1]) v = v & P0_PIN_B_CLR;
		end else if (cfg.port0_mode == MODE_JOY) begin
			if (j0[1]) v = v & P0_PIN_A_CLR;
			if (j0[2]) v = v & P0_PIN_B_CLR;
		end
		if (cfg.port1_mode == MODE_JOY) begin
			if (j1[1]) v = v & P1_PIN_A_CLR;
			if (j1[2]) v = v & P1_PIN_B_CLR;
		end
		return v;
	endfunction

endpackage

`default_nettype wire

>>> src/game_port_input_registers_unit.sv
// Top level of the game-port input register unit.
// Depends on gpir_pkg and gpir_mouse_axis.
//
// Usage: each request on the slave stream is one register access; its kind
// travels in s_tuser, the pointer position, buttons, joystick images and
// write data in s_tdata. Every request yields exactly one response on the
// master stream carrying the 16-bit read value (zero for write accesses).
// Flow: an accepted request is registered in the input stage, processed in
// one pass, and its response is then held in the response register.
// Throughput: one request per cycle while m_tready stays high; the input stage
// and the response register form a two-entry pipeline, so a new request is
// taken while a finished response still waits. When m_tready is low the
// response register holds, the input stage fills and s_tready then drops.
// Configuration (port modes, raw counting) is to be written by the user through
// the APB port while no request is in flight; the block does not enforce this;
// pready is always high. Reset: arst_n clears both stages, the pot and mouse
// state, port 0 to mouse, port 1 to joystick and raw counting off.
`default_nettype none

module game_port_input_registers_unit
	import gpir_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// slave stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// s_tdata, low bit up: write_data[15:0], pointer_x[31:16], pointer_y[47:32],
	// mouse_buttons[50:48], joy0_buttons[53:51], joy1_buttons[56:54],
	// joy0_direction[72:57], joy1_direction[88:73], zero fill[95:89]
	input  wire logic [95:0] s_tdata,
	// s_tuser: kind[2:0]
	input  wire logic [2:0]  s_tuser,
	// master stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// m_tdata: read_data[15:0]
	output logic [15:0]      m_tdata,
	// APB configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	cfg_t cfg_q;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.port0_mode <= MODE_MOUSE;
			cfg_q.port1_mode <= MODE_JOY;
			cfg_q.raw        <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_PORT0_MODE: cfg_q.port0_mode <= pwdata[MODE_W-1:0];
				REG_PORT1_MODE: cfg_q.port1_mode <= pwdata[MODE_W-1:0];
				REG_RAW:        cfg_q.raw        <= pwdata[0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_PORT0_MODE: prdata = {30'd0, cfg_q.port0_mode};
			REG_PORT1_MODE: prdata = {30'd0, cfg_q.port1_mode};
			REG_RAW:        prdata = {31'd0, cfg_q.raw};
			default:        prdata = 32'd0;
		endcase
	end

	// ---------------------------------------------------------------
	// Input stage: hold one request
	// ---------------------------------------------------------------
	logic        valid_s1;
	kind_t       kind_s1;
	logic [95:0] data_s1;
	logic        adv_s1;

	// advance when the response register is free or being emptied
	assign adv_s1   = valid_s1 & (~m_tvalid | m_tready);
	assign s_tready = ~valid_s1 | adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1 <= kind_t'(s_tuser);
			data_s1 <= s_tdata;
		end
	end

	// unpack the held request
	logic [DATA_W-1:0] wdata;
	logic [AXIS_W-1:0] ptr_x;
	logic [AXIS_W-1:0] ptr_y;
	logic [BTN_W-1:0]  mbtn;
	logic [BTN_W-1:0]  j0btn;
	logic [BTN_W-1:0]  j1btn;
	logic [DATA_W-1:0] j0dir;
	logic [DATA_W-1:0] j1dir;

	assign wdata = data_s1[15:0];
	assign ptr_x = data_s1[31:16];
	assign ptr_y = data_s1[47:32];
	assign mbtn  = data_s1[50:48];
	assign j0btn = data_s1[53:51];
	assign j1btn = data_s1[56:54];
	assign j0dir = data_s1[72:57];
	assign j1dir = data_s1[88:73];

	// ---------------------------------------------------------------
	// Port state
	// ---------------------------------------------------------------
	logic [DATA_W-1:0] pot_go_q;
	logic [DATA_W-1:0] pot_cnt_q;
	logic [CNT_W-1:0]  count_x_q;
	logic [CNT_W-1:0]  count_y_q;
	logic [AXIS_W-1:0] samp_x_q;
	logic [AXIS_W-1:0] samp_y_q;

	logic [AXIS_W-1:0] samp_x_nx;
	logic [AXIS_W-1:0] samp_y_nx;
	logic [CNT_W-1:0]  count_x_nx;
	logic [CNT_W-1:0]  count_y_nx;

	gpir_mouse_axis u_axis_x (
		.ptr       (ptr_x),
		.samp      (samp_x_q),
		.cnt       (count_x_q),
		.raw       (cfg_q.raw),
		.samp_next (samp_x_nx),
		.cnt_next  (count_x_nx)
	);

	gpir_mouse_axis u_axis_y (
		.ptr       (ptr_y),
		.samp      (samp_y_q),
		.cnt       (count_y_q),
		.raw       (cfg_q.raw),
		.samp_next (samp_y_nx),
		.cnt_next  (count_y_nx)
	);

	logic              p0_mouse;
	logic              mouse_rd;
	logic [DATA_W-1:0] pot_cnt_nx;
	logic [DATA_W-1:0] rdata;

	assign p0_mouse = (cfg_q.port0_mode == MODE_MOUSE);

	always_comb begin
		// button counter: low byte for one button, high byte for the other
		pot_cnt_nx = pot_cnt_q;
		if (p0_mouse) begin
			if (mbtn[2]) pot_cnt_nx[7:0]  = pot_cnt_q[7:0] + 8'd1;
			if (mbtn[1]) pot_cnt_nx[15:8] = pot_cnt_q[15:8] + 8'd1;
		end

		mouse_rd = 1'b0;
		unique case (kind_s1)
			KIND_POTGO_READ: rdata = pot_pin_image(pot_go_q, cfg_q, mbtn, j0btn, j1btn);
			KIND_POT0_READ:  rdata = pot_cnt_nx;
			KIND_PORT0_READ: begin
				mouse_rd = p0_mouse;
				rdata    = p0_mouse ? {count_y_nx, count_x_nx} : j0dir;
			end
			KIND_PORT1_READ: begin
				mouse_rd = (cfg_q.port1_mode == MODE_MOUSE);
				rdata    = mouse_rd ? {count_y_nx, count_x_nx} : j1dir;
			end
			default:         rdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pot_go_q  <= '0;
			pot_cnt_q <= '0;
			count_x_q <= '0;
			count_y_q <= '0;
			samp_x_q  <= '0;
			samp_y_q  <= '0;
		end else if (adv_s1) begin
			if (kind_s1 == KIND_POTGO_WRITE) begin
				pot_go_q <= wdata;
			end
			if (kind_s1 == KIND_POT0_READ) begin
				pot_cnt_q <= pot_cnt_nx;
			end
			if (mouse_rd) begin
				count_x_q <= count_x_nx;
				count_y_q <= count_y_nx;
				samp_x_q  <= samp_x_nx;
				samp_y_q  <= samp_y_nx;
			end else if (kind_s1 == KIND_TEST_WRITE && p0_mouse) begin
				// test write presets the counters, low two bits dropped
				count_x_q <= wdata[7:0] & TEST_MASK;
				count_y_q <= wdata[15:8] & TEST_MASK;
			end
		end
	end

	// ---------------------------------------------------------------
	// Response register
	// ---------------------------------------------------------------
	logic              m_valid_q;
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (~m_valid_q | m_tready) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rdata_q <= rdata;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = rdata_q;

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty response register");

	a_resp_drop_taken: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(m_tvalid) |-> $past(m_tready))
		else $error("response dropped without being taken");

	a_potgo_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(adv_s1 && kind_s1 == KIND_POTGO_WRITE) |=> $stable(pot_go_q))
		else $error("pot-go changed without a pot-go write");

	a_raw_counts_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_q.raw && !(adv_s1 && kind_s1 == KIND_TEST_WRITE))
		|=> $stable({count_y_q, count_x_q}))
		else $error("mouse counters moved in raw counting mode");

endmodule

`default_nettype wire

>>> src/gpir_mouse_axis.sv
// One mouse axis: delta against the sample point, clamp, count update.
// Depends on gpir_pkg.
`default_nettype none

module gpir_mouse_axis
	import gpir_pkg::*;
(
	input  wire logic [AXIS_W-1:0] ptr,
	input  wire logic [AXIS_W-1:0] samp,
	input  wire logic [CNT_W-1:0]  cnt,
	input  wire logic              raw,
	output logic      [AXIS_W-1:0] samp_next,
	output logic      [CNT_W-1:0]  cnt_next
);

	logic signed [AXIS_W:0] delta;
	logic signed [AXIS_W:0] clamped;

	always_comb begin
		delta = $signed({ptr[AXIS_W-1], ptr}) - $signed({samp[AXIS_W-1], samp});
		if (delta > (AXIS_W+1)'(DELTA_LIMIT)) begin
			clamped = (AXIS_W+1)'(DELTA_LIMIT);
		end else if (delta < -(AXIS_W+1)'(DELTA_LIMIT)) begin
			clamped = -(AXIS_W+1)'(DELTA_LIMIT);
		end else begin
			clamped = delta;
		end
		// raw counting: follow the pointer, leave the count alone
		if (raw) begin
			samp_next = samp + delta[AXIS_W-1:0];
			cnt_next  = cnt;
		end else begin
			samp_next = samp + clamped[AXIS_W-1:0];
			cnt_next  = cnt + clamped[CNT_W-1:0];
		end
	end

endmodule

`default_nettype wire
